### src/assert_macros.svh
// assertion macros used by the rtl back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WPGA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wpga assertion failed");
// next-cycle implication
`define WPGA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wpga assertion failed");
`else
`define WPGA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WPGA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/wpga_pkg.sv
package wpga_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;

    localparam int QUEUE_DEPTH = 2;

    // r * |d.e| is below 2^81
    localparam int DVD_W     = 81;
    localparam int DIV_STEPS = DVD_W;
    localparam int SAT_IN_W  = 66;

    typedef struct packed {
        logic               last;
        logic               zero;
        logic               dp_ovf;
        logic signed [31:0] dp;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic signed [17:0] ex;
        logic signed [17:0] ey;
        logic signed [17:0] ez;
        logic        [30:0] r;
        logic signed [31:0] dw;
        logic        [30:0] vol;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } t_sat;

    localparam logic signed [SAT_IN_W-1:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN = -66'sd2147483648;

    function automatic t_sat sat32(input logic signed [SAT_IN_W-1:0] x);
        t_sat res;
        res.ovf = 1'b0;
        res.val = x[31:0];
        if (x > SAT_MAX) begin
            res.ovf = 1'b1;
            res.val = 32'sh7fff_ffff;
        end else if (x < SAT_MIN) begin
            res.ovf = 1'b1;
            res.val = 32'sh8000_0000;
        end
        return res;
    endfunction

endpackage

### src/wpga_if.sv
interface wpga_in_if;
    logic               valid;
    logic               ready;
    logic               last_neighbour;
    logic signed [31:0] own_pressure;
    logic signed [31:0] wall_dist_x;
    logic signed [31:0] wall_dist_y;
    logic signed [31:0] wall_dist_z;
    logic signed [31:0] neighbour_pressure;
    logic signed [17:0] unit_x;
    logic signed [17:0] unit_y;
    logic signed [17:0] unit_z;
    logic        [30:0] pair_distance;
    logic signed [31:0] kernel_slope;
    logic        [30:0] neighbour_volume;

    modport source(
        output valid, last_neighbour, own_pressure, wall_dist_x, wall_dist_y, wall_dist_z,
        output neighbour_pressure, unit_x, unit_y, unit_z, pair_distance, kernel_slope,
        output neighbour_volume,
        input  ready
    );
    modport sink(
        input  valid, last_neighbour, own_pressure, wall_dist_x, wall_dist_y, wall_dist_z,
        input  neighbour_pressure, unit_x, unit_y, unit_z, pair_distance, kernel_slope,
        input  neighbour_volume,
        output ready
    );
endinterface

interface wpga_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               overflow;

    modport source(output valid, grad_x, grad_y, grad_z, overflow, input ready);
    modport sink(input valid, grad_x, grad_y, grad_z, overflow, output ready);
endinterface

### src/wpga_front.sv
module wpga_front (
    wpga_in_if.sink          i_in,
    input  wpga_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output wpga_pkg::t_task  o_task
);

    wpga_pkg::t_sat dp_sat;

    // pressure difference and zero wall distance are settled here
    assign dp_sat = wpga_pkg::sat32(
        wpga_pkg::SAT_IN_W'(i_in.own_pressure) - wpga_pkg::SAT_IN_W'(i_in.neighbour_pressure));

    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    always_comb begin
        o_task.last   = i_in.last_neighbour;
        o_task.zero   = (i_in.wall_dist_x | i_in.wall_dist_y | i_in.wall_dist_z) == 32'sd0;
        o_task.dp_ovf = dp_sat.ovf;
        o_task.dp     = dp_sat.val;
        o_task.dx     = i_in.wall_dist_x;
        o_task.dy     = i_in.wall_dist_y;
        o_task.dz     = i_in.wall_dist_z;
        o_task.ex     = i_in.unit_x;
        o_task.ey     = i_in.unit_y;
        o_task.ez     = i_in.unit_z;
        o_task.r      = i_in.pair_distance;
        o_task.dw     = i_in.kernel_slope;
        o_task.vol    = i_in.neighbour_volume;
    end

endmodule

### src/wpga_queue.sv
module wpga_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wpga_pkg::t_task   i_task,
    input  logic              i_pop,
    output wpga_pkg::t_task   o_task,
    output wpga_pkg::t_q_stat o_q_stat
);

    localparam int PTR_W = (wpga_pkg::QUEUE_DEPTH > 1) ? $clog2(wpga_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(wpga_pkg::QUEUE_DEPTH + 1);

    wpga_pkg::t_task r_mem [wpga_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_task         = r_mem[r_rd_ptr];
    assign o_q_stat.full  = r_count == CNT_W'(wpga_pkg::QUEUE_DEPTH);
    assign o_q_stat.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(wpga_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(wpga_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/wpga_back.sv
`include "assert_macros.svh"

module wpga_back #(
    parameter int FRAC_BITS = wpga_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = wpga_pkg::ACC_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wpga_pkg::t_q_stat i_q_stat,
    input  wpga_pkg::t_task   i_task,
    output logic              o_pop,
    wpga_out_if.source        o_out
);

    localparam int C_W   = 50;
    localparam int DIF_W = ((ACC_WIDTH > C_W) ? ACC_WIDTH : C_W) + 1;
    localparam int CNT_W = $clog2(wpga_pkg::DIV_STEPS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_P1   = 4'd1;
    localparam logic [3:0] S_P2   = 4'd2;
    localparam logic [3:0] S_P3   = 4'd3;
    localparam logic [3:0] S_P4   = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_F    = 4'd6;
    localparam logic [3:0] S_S    = 4'd7;
    localparam logic [3:0] S_M    = 4'd8;
    localparam logic [3:0] S_C    = 4'd9;
    localparam logic [3:0] S_A    = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    localparam logic signed [DIF_W-1:0] ACC_MAX =
        {{(DIF_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [DIF_W-1:0] ACC_MIN = ~ACC_MAX;

    // acc - c clamped to the accumulator range, flag on top
    function automatic logic [ACC_WIDTH:0] acc_step(input logic signed [ACC_WIDTH-1:0] acc,
                                                    input logic signed [C_W-1:0] c);
        logic signed [DIF_W-1:0] diff;
        diff = DIF_W'(acc) - DIF_W'(c);
        if (diff > ACC_MAX) begin
            return {1'b1, ACC_MAX[ACC_WIDTH-1:0]};
        end else if (diff < ACC_MIN) begin
            return {1'b1, ACC_MIN[ACC_WIDTH-1:0]};
        end
        return {1'b0, diff[ACC_WIDTH-1:0]};
    endfunction

    logic [3:0]                   r_state;
    wpga_pkg::t_task              r_task;
    logic signed [63:0]           r_sq_x, r_sq_y, r_sq_z;
    logic signed [C_W-1:0]        r_pe_x, r_pe_y, r_pe_z;
    logic signed [63:0]           r_pw;
    logic        [63:0]           r_dd;
    logic                         r_neg;
    logic        [49:0]           r_mag;
    logic signed [31:0]           r_w;
    logic        [55:0]           r_pl, r_ph;
    logic [wpga_pkg::DVD_W-1:0]   r_dvd;
    logic        [63:0]           r_rem;
    logic        [31:0]           r_q;
    logic                         r_qhi;
    logic [CNT_W-1:0]             r_cnt;
    logic signed [31:0]           r_f;
    logic signed [63:0]           r_prod;
    logic signed [C_W-1:0]        r_cx, r_cy, r_cz;
    logic signed [ACC_WIDTH-1:0]  r_acc_x, r_acc_y, r_acc_z;
    logic                         r_sticky;
    logic                         r_out_valid;
    logic signed [31:0]           r_gx, r_gy, r_gz;
    logic                         r_govf;

    logic signed [51:0]  de;
    logic        [51:0]  de_abs;
    wpga_pkg::t_sat      w_sat, s_sat, m_sat, gx_sat, gy_sat, gz_sat;
    logic        [64:0]  rem_sh;
    logic                rem_ge;
    logic        [31:0]  q_lim;
    logic                q_big;
    logic        [31:0]  q_sat;
    logic signed [32:0]  f_full;
    logic [ACC_WIDTH:0]  ax_n, ay_n, az_n;
    logic                out_free;

    assign de     = r_pe_x + r_pe_y + r_pe_z;
    assign de_abs = de[51] ? 52'(-de) : 52'(de);
    assign w_sat  = wpga_pkg::sat32(wpga_pkg::SAT_IN_W'(r_pw >>> FRAC_BITS));
    assign s_sat  = wpga_pkg::sat32(wpga_pkg::SAT_IN_W'(r_prod >>> FRAC_BITS));
    assign m_sat  = s_sat;

    assign rem_sh = {r_rem, r_dvd[wpga_pkg::DVD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dd};

    assign q_lim  = r_neg ? 32'h8000_0000 : 32'h7fff_ffff;
    assign q_big  = r_qhi || (r_q > q_lim);
    assign q_sat  = q_big ? q_lim : r_q;
    assign f_full = r_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});

    assign ax_n = acc_step(r_acc_x, r_cx >>> FRAC_BITS);
    assign ay_n = acc_step(r_acc_y, r_cy >>> FRAC_BITS);
    assign az_n = acc_step(r_acc_z, r_cz >>> FRAC_BITS);

    assign gx_sat = wpga_pkg::sat32(wpga_pkg::SAT_IN_W'(r_acc_x));
    assign gy_sat = wpga_pkg::sat32(wpga_pkg::SAT_IN_W'(r_acc_y));
    assign gz_sat = wpga_pkg::sat32(wpga_pkg::SAT_IN_W'(r_acc_z));

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;

    assign o_out.valid    = r_out_valid;
    assign o_out.grad_x   = r_gx;
    assign o_out.grad_y   = r_gy;
    assign o_out.grad_z   = r_gz;
    assign o_out.overflow = r_govf;

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_task <= i_task;
            end
            S_P1: begin
                r_sq_x <= r_task.dx * r_task.dx;
                r_sq_y <= r_task.dy * r_task.dy;
                r_sq_z <= r_task.dz * r_task.dz;
                r_pe_x <= r_task.dx * r_task.ex;
                r_pe_y <= r_task.dy * r_task.ey;
                r_pe_z <= r_task.dz * r_task.ez;
                r_pw   <= r_task.dw * $signed({1'b0, r_task.vol});
            end
            S_P2: begin
                r_dd  <= 64'(r_sq_x) + 64'(r_sq_y) + 64'(r_sq_z);
                r_neg <= de[51];
                r_mag <= de_abs[49:0];
                r_w   <= w_sat.val;
            end
            S_P3: begin
                r_pl <= r_task.r * r_mag[24:0];
                r_ph <= r_task.r * r_mag[49:25];
            end
            S_P4: begin
                r_dvd <= wpga_pkg::DVD_W'(r_pl) + (wpga_pkg::DVD_W'(r_ph) << 25);
                r_rem <= '0;
                r_q   <= '0;
                r_qhi <= 1'b0;
            end
            S_DIV: begin
                r_rem <= rem_ge ? 64'(rem_sh - {1'b0, r_dd}) : rem_sh[63:0];
                r_q   <= {r_q[30:0], rem_ge};
                r_qhi <= r_qhi | r_q[31];
                r_dvd <= r_dvd << 1;
            end
            S_F: begin
                r_f <= f_full[31:0];
            end
            S_S: begin
                r_prod <= r_f * r_task.dp;
            end
            S_M: begin
                r_prod <= s_sat.val * r_w;
            end
            S_C: begin
                r_cx <= m_sat.val * r_task.ex;
                r_cy <= m_sat.val * r_task.ey;
                r_cz <= m_sat.val * r_task.ez;
            end
            default: begin
            end
        endcase
    end

    // sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_z     <= '0;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_state <= S_P1;
                    end
                end
                S_P1: begin
                    if (r_task.zero) begin
                        r_sticky <= 1'b1;
                        r_state  <= r_task.last ? S_OUT : S_IDLE;
                    end else begin
                        r_sticky <= r_sticky | r_task.dp_ovf;
                        r_state  <= S_P2;
                    end
                end
                S_P2: begin
                    r_sticky <= r_sticky | w_sat.ovf;
                    r_state  <= S_P3;
                end
                S_P3: begin
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(wpga_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_F;
                    end
                end
                S_F: begin
                    r_sticky <= r_sticky | q_big;
                    r_state  <= S_S;
                end
                S_S: begin
                    r_state <= S_M;
                end
                S_M: begin
                    r_sticky <= r_sticky | s_sat.ovf;
                    r_state  <= S_C;
                end
                S_C: begin
                    r_sticky <= r_sticky | m_sat.ovf;
                    r_state  <= S_A;
                end
                S_A: begin
                    r_acc_x  <= ax_n[ACC_WIDTH-1:0];
                    r_acc_y  <= ay_n[ACC_WIDTH-1:0];
                    r_acc_z  <= az_n[ACC_WIDTH-1:0];
                    r_sticky <= r_sticky | ax_n[ACC_WIDTH] | ay_n[ACC_WIDTH] | az_n[ACC_WIDTH];
                    r_state  <= r_task.last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_gx        <= gx_sat.val;
                        r_gy        <= gy_sat.val;
                        r_gz        <= gz_sat.val;
                        r_govf      <= r_sticky | gx_sat.ovf | gy_sat.ovf | gz_sat.ovf;
                        r_acc_x     <= '0;
                        r_acc_y     <= '0;
                        r_acc_z     <= '0;
                        r_sticky    <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `WPGA_ASSERT_IMP(a_out_only_from_finish, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_OUT)
    `WPGA_ASSERT_NXT(a_cleared_after_emit, i_clk, i_rst_n, (r_state == S_OUT) && out_free, !r_sticky && (r_acc_x == '0) && (r_acc_y == '0) && (r_acc_z == '0))
    `WPGA_ASSERT_NXT(a_pop_starts_work, i_clk, i_rst_n, o_pop, r_state == S_P1)
    `WPGA_ASSERT_IMP(a_div_count_bounded, i_clk, i_rst_n, r_state == S_DIV, r_cnt <= CNT_W'(wpga_pkg::DIV_STEPS - 1))

endmodule

### src/wall_pressure_gradient_accumulate_unit.sv
// channel  | dir | contents
// i_in     | in  | one wall neighbour of the current particle, last_neighbour closes it
// o_out    | out | gradient increment x/y/z and overflow, one word per particle
//
// a nonzero item passes the back end's 10 sequencer steps (idle/pop included) and
// the 81-step restoring divider for r*|d.e|/|d|^2, one quotient bit per cycle
// an item with zero wall distance leaves from P1; a last item goes on to the emit state,
// which waits while the previous output word is still waiting to be taken
// i_rst_n is synchronous, active low, and clears accumulators, queue and output valid
// the front takes words while the 2-deep queue has room, independent of the back end
// the output register lets the back end keep working while a result waits
module wall_pressure_gradient_accumulate_unit #(
    parameter int FRAC_BITS = wpga_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = wpga_pkg::ACC_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wpga_in_if.sink    i_in,
    wpga_out_if.source o_out
);

    // front to queue
    logic              push;
    wpga_pkg::t_task   push_task;
    // queue to back end
    logic              pop;
    wpga_pkg::t_task   head_task;
    wpga_pkg::t_q_stat q_stat;

    // front: pressure difference, zero wall distance check
    wpga_front u_front (
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_task   (push_task)
    );

    // decoupling queue
    wpga_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_task   (push_task),
        .i_pop    (pop),
        .o_task   (head_task),
        .o_q_stat (q_stat)
    );

    // back end: correction factor, contribution, accumulate and emit
    wpga_back #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_task   (head_task),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
